// ===== sv/swmma_pkg.sv =====
package swmma_pkg;

	localparam int DEPTH_DEFAULT = 256;

	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int SAMPLE_W = 16;
	localparam int MARGIN_W = 15;
	localparam int COUNT_W  = 9;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic REG_DYN_SCALE_EN = 1'b0;
	localparam logic REG_SCALE_MARGIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ===== sv/swmma_if.sv =====
interface swmma_in_if;
	import swmma_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       command;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink (input valid, input command, input sample, output ready);

endinterface

interface swmma_out_if;
	import swmma_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] window_min;
	logic signed [SAMPLE_W-1:0] window_max;
	logic signed [SAMPLE_W-1:0] window_average;
	logic [COUNT_W-1:0]         fill_count;
	logic [MARGIN_W-1:0]        scale_low;
	logic signed [SAMPLE_W-1:0] scale_high;

	modport source (output valid, output window_min, output window_max,
		output window_average, output fill_count, output scale_low,
		output scale_high, input ready);
	modport sink (input valid, input window_min, input window_max,
		input window_average, input fill_count, input scale_low,
		input scale_high, output ready);

endinterface

// ===== sv/swmma_ring.sv =====
module swmma_ring
	import swmma_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic signed [SAMPLE_W-1:0] rd_data
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/swmma_div.sv =====
module swmma_div
	import swmma_pkg::*;
#(
	parameter int TW = 24,
	parameter int CW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [TW-1:0]       dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int IW = $clog2(TW + 1);

	logic          busy_q;
	logic          done_q;
	logic [IW-1:0] iter_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] div_q;
	logic [TW-1:0] quo_q;
	logic          neg_q;
	logic [CW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[TW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IW'(TW);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[TW-1];
			quo_q <= dividend[TW-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CW'(trial - {1'b0, div_q}) : trial[CW-1:0];
			quo_q <= {quo_q[TW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q[SAMPLE_W-1:0] : quo_q[SAMPLE_W-1:0];

endmodule

// ===== sv/sliding_window_min_max_average.sv =====
// Sliding-window min / max / average over signed Q8.8 samples. An add item
// writes the sample over the oldest slot of a DEPTH-entry ring memory, then
// reads back the fill_count newest entries one per cycle to find min and max,
// then divides the running total by the count in a bit-serial divider. A clear
// item needs no clearing pass: entries beyond the fill count are never scanned
// and count as zero in the running total. The next item is taken while the
// last result still waits in the output register.
// Registers: 0x0 dynamic scale enable (bit 0), 0x4 scale margin (bits 14:0).
module sliding_window_min_max_average
	import swmma_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	swmma_in_if.sink          in_ch,
	swmma_out_if.source       out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = SAMPLE_W + AW;

	state_t state_q, state_d;

	logic                       dyn_en_q;
	logic [MARGIN_W-1:0]        margin_q;
	logic [AW-1:0]              wp_q;
	logic [CW-1:0]              count_q;
	logic signed [TW-1:0]       total_q;
	logic [MARGIN_W-1:0]        scale_low_q;
	logic signed [SAMPLE_W-1:0] scale_high_q;
	logic                       clr_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [AW-1:0]              scan_addr_q;
	logic [CW-1:0]              issue_cnt_q;
	logic                       rd_valid_s1;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_min_q;
	logic signed [SAMPLE_W-1:0] out_max_q;
	logic signed [SAMPLE_W-1:0] out_avg_q;
	logic [COUNT_W-1:0]         out_count_q;

	logic                       in_ready;
	logic                       in_take;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic                       div_start;
	logic                       out_load;
	logic                       scan_issue;
	logic                       scan_end;
	logic                       cfg_wr;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic signed [SAMPLE_W-1:0] old_val;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] div_quo;
	logic signed [SAMPLE_W:0]   lo_sum;
	logic signed [SAMPLE_W+1:0] hi_sum;
	logic [MARGIN_W-1:0]        lo_sat;
	logic signed [SAMPLE_W-1:0] hi_sat;
	logic [AW-1:0]              wp_next;
	logic [AW-1:0]              scan_addr_next;

	swmma_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (sample_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swmma_div #(.TW(TW), .CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_DYN_SCALE_EN: prdata = {{(DATA_W-1){1'b0}}, dyn_en_q};
			REG_SCALE_MARGIN: prdata = {{(DATA_W-MARGIN_W){1'b0}}, margin_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dyn_en_q <= 1'b0;
			margin_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DYN_SCALE_EN: dyn_en_q <= pwdata[0];
				REG_SCALE_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
				default:          dyn_en_q <= dyn_en_q;
			endcase
		end
	end

	assign in_take    = in_ch.valid && in_ready;
	assign scan_issue = (state_q == ST_SCAN) && (issue_cnt_q != count_q);
	assign scan_end   = (state_q == ST_SCAN) && (issue_cnt_q == count_q) && !rd_valid_s1;
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	assign old_val        = (count_q == CW'(DEPTH)) ? rd_data : '0;
	assign wp_next        = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign scan_addr_next = (scan_addr_q == '0) ? AW'(DEPTH - 1) : scan_addr_q - 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = (in_ch.command == CMD_CLEAR) ? ST_FIN : ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = wp_q;
		wr_en     = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_take;
			end
			ST_UPDATE: wr_en = 1'b1;
			ST_SCAN: begin
				rd_en     = scan_issue;
				rd_addr   = scan_addr_q;
				div_start = scan_end;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			count_q     <= '0;
			total_q     <= '0;
			scale_low_q <= '0;
			scale_high_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= scan_issue;
			if (in_take && in_ch.command == CMD_CLEAR) begin
				wp_q    <= '0;
				count_q <= '0;
				total_q <= '0;
			end
			if (state_q == ST_UPDATE) begin
				total_q <= total_q - {{(TW-SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val}
					+ {{(TW-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
				wp_q <= wp_next;
				if (count_q != CW'(DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!clr_q && dyn_en_q) begin
					scale_low_q  <= lo_sat;
					scale_high_q <= hi_sat;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scale bounds from the fresh min and max
	assign lo_sum = {min_q[SAMPLE_W-1], min_q} - {2'b00, margin_q};
	assign hi_sum = {{2{max_q[SAMPLE_W-1]}}, max_q} + {3'b000, margin_q};
	assign lo_sat = lo_sum[SAMPLE_W] ? '0 : lo_sum[MARGIN_W-1:0];
	assign hi_sat = (hi_sum > $signed({2'b00, SAMPLE_MAX})) ? SAMPLE_MAX
		: hi_sum[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= in_ch.sample;
			clr_q    <= in_ch.command;
			if (in_ch.command == CMD_CLEAR) begin
				min_q <= '0;
				max_q <= '0;
				avg_q <= '0;
			end
		end
		if (state_q == ST_UPDATE) begin
			scan_addr_q <= wp_q;
			issue_cnt_q <= '0;
			min_q       <= SAMPLE_MAX;
			max_q       <= SAMPLE_MIN;
		end
		if (scan_issue) begin
			scan_addr_q <= scan_addr_next;
			issue_cnt_q <= issue_cnt_q + 1'b1;
		end
		if (rd_valid_s1) begin
			if (rd_data < min_q) begin
				min_q <= rd_data;
			end
			if (rd_data > max_q) begin
				max_q <= rd_data;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			avg_q <= div_quo;
		end
		if (out_load) begin
			out_min_q   <= min_q;
			out_max_q   <= max_q;
			out_avg_q   <= avg_q;
			out_count_q <= COUNT_W'(count_q);
		end
	end

	assign in_ch.ready           = in_ready;
	assign out_ch.valid          = out_valid_q;
	assign out_ch.window_min     = out_min_q;
	assign out_ch.window_max     = out_max_q;
	assign out_ch.window_average = out_avg_q;
	assign out_ch.fill_count     = out_count_q;
	assign out_ch.scale_low      = scale_low_q;
	assign out_ch.scale_high     = scale_high_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_ch.command == CMD_CLEAR) |=> (count_q == '0 && total_q == '0))
		else $error("clear left window state");

	a_no_scan_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_valid_s1)
		else $error("scan read pending while taking an item");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final state");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import swmma_pkg::*;

	localparam int WIN_DEPTH = DEPTH_DEFAULT;
	localparam int RANDOM_PER_PHASE = 130;
	localparam int LONG_RUN = 300;
	localparam int NUM_PHASES = 8;

	typedef struct {
		logic                       command;
		logic signed [SAMPLE_W-1:0] sample;
	} window_item_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] window_min;
		logic signed [SAMPLE_W-1:0] window_max;
		logic signed [SAMPLE_W-1:0] window_average;
		logic [COUNT_W-1:0]         fill_count;
		logic [MARGIN_W-1:0]        scale_low;
		logic signed [SAMPLE_W-1:0] scale_high;
	} window_stats_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	swmma_in_if  in_ch();
	swmma_out_if out_ch();

	sliding_window_min_max_average u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	window_item_t  pending_items[$];
	window_stats_t expected_stats[$];

	logic signed [SAMPLE_W-1:0] hist_ring[WIN_DEPTH];
	int hist_pos;
	int hist_count;
	int hist_total;
	int disp_low;
	int disp_high;
	int cfg_scale_en;
	int cfg_margin;

	int  send_idle_pct;
	int  recv_stall_pct;
	int  err_count;
	int  result_no;
	bit  in_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic window_stats_t predict_window(input logic cmd,
		input logic signed [SAMPLE_W-1:0] smp);
		window_stats_t r;
		int mn;
		int mx;
		int avg;
		int lo;
		int hi;
		int v;
		mn = 0;
		mx = 0;
		avg = 0;
		if (cmd == CMD_CLEAR) begin
			foreach (hist_ring[i])
				hist_ring[i] = '0;
			hist_pos = 0;
			hist_count = 0;
			hist_total = 0;
		end else begin
			hist_total = hist_total - int'(hist_ring[hist_pos]) + int'(smp);
			hist_ring[hist_pos] = smp;
			hist_pos = (hist_pos + 1) % WIN_DEPTH;
			if (hist_count < WIN_DEPTH)
				hist_count++;
			mn = 32767;
			mx = -32768;
			for (int i = 0; i < hist_count; i++) begin
				v = hist_ring[(hist_pos + WIN_DEPTH - 1 - i) % WIN_DEPTH];
				if (v < mn)
					mn = v;
				if (v > mx)
					mx = v;
			end
			avg = hist_total / hist_count;
			if (cfg_scale_en != 0) begin
				lo = mn - cfg_margin;
				hi = mx + cfg_margin;
				disp_low = (lo < 0) ? 0 : lo;
				disp_high = (hi > 32767) ? 32767 : hi;
			end
		end
		r.window_min = SAMPLE_W'(mn);
		r.window_max = SAMPLE_W'(mx);
		r.window_average = SAMPLE_W'(avg);
		r.fill_count = COUNT_W'(hist_count);
		r.scale_low = MARGIN_W'(disp_low);
		r.scale_high = SAMPLE_W'(disp_high);
		return r;
	endfunction

	function automatic void check_field(input string field, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			err_count++;
			if (err_count <= 10)
				$display("result %0d: %s expected %0d, got %0d", result_no, field, exp_v,
					act_v);
		end
	endfunction

	// acceptance, prediction and result checking
	always @(posedge clk) begin
		window_stats_t exp_r;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			in_taken = in_ch.valid && in_ch.ready;
			if (in_taken)
				expected_stats.push_back(predict_window(in_ch.command, in_ch.sample));
			if (out_ch.valid && out_ch.ready) begin
				result_no++;
				if (expected_stats.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("result %0d arrived with no item outstanding", result_no);
				end else begin
					exp_r = expected_stats.pop_front();
					check_field("window_min", exp_r.window_min, out_ch.window_min);
					check_field("window_max", exp_r.window_max, out_ch.window_max);
					check_field("window_average", exp_r.window_average,
						out_ch.window_average);
					check_field("fill_count", exp_r.fill_count, out_ch.fill_count);
					check_field("scale_low", exp_r.scale_low, out_ch.scale_low);
					check_field("scale_high", exp_r.scale_high, out_ch.scale_high);
				end
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		window_item_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.command <= it.command;
				in_ch.sample <= it.sample;
			end else begin
				in_ch.valid <= 1'b0;
				in_ch.command <= 1'($urandom);
				in_ch.sample <= SAMPLE_W'($urandom);
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic push_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp);
		window_item_t it;
		it.command = cmd;
		it.sample = smp;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return SAMPLE_W'($urandom_range(0, 512) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// mostly cleared windows of modest size, now and then a window left to grow
	task automatic queue_random_items(input int n, input bit with_long_run);
		int left;
		int seg;
		left = n;
		if (with_long_run) begin
			push_item(CMD_CLEAR, SAMPLE_W'($urandom));
			for (int k = 0; k < LONG_RUN; k++)
				push_item(CMD_ADD, rand_sample());
		end
		while (left > 0) begin
			seg = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				push_item(CMD_CLEAR, SAMPLE_W'($urandom));
			for (int k = 0; k < seg; k++) begin
				if ($urandom_range(0, 19) == 0)
					push_item(CMD_CLEAR, SAMPLE_W'($urandom));
				else
					push_item(CMD_ADD, rand_sample());
			end
			left -= seg + 1;
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_items.size() > 0 || in_ch.valid || expected_stats.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_DYN_SCALE_EN)
			cfg_scale_en = data[0];
		else
			cfg_margin = data[MARGIN_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pwdata <= '0;
	endtask

	task automatic queue_directed(input int ph);
		case (ph)
			0: begin
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_MAX);
				push_item(CMD_ADD, SAMPLE_MIN);
				push_item(CMD_ADD, -SAMPLE_W'(1));
				push_item(CMD_ADD, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_W'(1));
				push_item(CMD_ADD, 16'sh5555);
				push_item(CMD_ADD, 16'shaaaa);
				push_item(CMD_CLEAR, 16'shffff);
				push_item(CMD_ADD, SAMPLE_MIN);
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				// negative average truncates toward zero
				push_item(CMD_ADD, -SAMPLE_W'(3));
				push_item(CMD_ADD, -SAMPLE_W'(2));
				push_item(CMD_ADD, SAMPLE_W'(4));
			end
			1: begin
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_MAX);
				push_item(CMD_ADD, SAMPLE_MIN);
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_W'(100));
			end
			2: begin
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_W'(1));
				push_item(CMD_CLEAR, SAMPLE_W'(0));
				push_item(CMD_ADD, SAMPLE_MIN);
				push_item(CMD_ADD, SAMPLE_MAX);
			end
			default: ;
		endcase
	endtask

	initial begin
		int en_v;
		int margin_v;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_ADD;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		in_taken = 1'b0;
		err_count = 0;
		result_no = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (hist_ring[i])
			hist_ring[i] = '0;
		hist_pos = 0;
		hist_count = 0;
		hist_total = 0;
		disp_low = 0;
		disp_high = 0;
		cfg_scale_en = 0;
		cfg_margin = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin en_v = 0; margin_v = 0; end
				1: begin en_v = 1; margin_v = 0; end
				2: begin en_v = 1; margin_v = 32767; end
				4: begin en_v = 0; margin_v = $urandom_range(0, 32767); end
				5: begin en_v = 1; margin_v = $urandom_range(0, 600); end
				6: begin en_v = 1; margin_v = 1; end
				default: begin en_v = 1; margin_v = $urandom_range(0, 32767); end
			endcase
			// stray upper bits must be dropped by the block
			write_reg(REG_DYN_SCALE_EN, ($urandom & ~32'h1) | DATA_W'(en_v));
			write_reg(REG_SCALE_MARGIN, ($urandom & ~32'h7fff) | DATA_W'(margin_v));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			queue_directed(ph);
			queue_random_items(RANDOM_PER_PHASE, ph == 2 || ph == 7);
		end

		wait_drained();
		repeat (400) @(posedge clk);
		if (expected_stats.size() != 0) begin
			err_count += expected_stats.size();
			$display("%0d results never arrived", expected_stats.size());
		end
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/swmma_pkg.sv
sv/swmma_if.sv
sv/swmma_ring.sv
sv/swmma_div.sv
sv/sliding_window_min_max_average.sv
verif/tb_top.sv
